// ----- design/evr_pkg.sv -----
// shared constants and helpers for the euler vector rotator
package evr_pkg;

  // default datapath widths
  localparam int COORD_WIDTH    = 32;
  localparam int TRIG_FRAC_BITS = 16;
  localparam int ANGLE_WIDTH    = 24;

  // angle units: 1/256 degree
  localparam int TURN_UNITS    = 92160;
  localparam int QUARTER_UNITS = 23040;
  localparam int EIGHTH_UNITS  = 11520;

  // turn = 2^11 * 45, quarter = 2^9 * 45
  localparam int MOD_STEPS  = 45;
  localparam int MOD_SHIFT  = 20;
  localparam int MOD_RECIP  = ((1 << MOD_SHIFT) + MOD_STEPS - 1) / MOD_STEPS;
  localparam int ANGLE_BIAS = 92 * TURN_UNITS;

  // series arithmetic, unsigned Q2.30
  localparam int SERIES_FRAC  = 30;
  localparam int RAD_WIDTH    = 30;
  localparam int SERIES_WIDTH = 31;
  localparam int ACC_WIDTH    = 32;
  localparam int NUM_TERMS    = 6;
  localparam int SIN_TERMS    = 5;
  localparam int DIV_SHIFT    = 39;
  localparam int DIV_WIDTH    = 39;

  // pi * 2^62 over 46080 scales 1/256 degree to radians in Q30 (before >> 32)
  localparam logic [63:0] PI_Q62    = 64'hC90FDAA22168C234;
  localparam logic [63:0] RAD_SCALE = PI_Q62 / 64'd46080;

  // pipeline depths
  localparam int TRIG_LATENCY = 5 + 2 * NUM_TERMS + 1;
  localparam int ROT_LATENCY  = 2;

  // taylor divisors
  function automatic int sin_div(input int n);
    return (2 * n) * (2 * n + 1);
  endfunction

  function automatic int cos_div(input int n);
    return (2 * n - 1) * (2 * n);
  endfunction

endpackage

// ----- design/evr_if.sv -----
// valid/ready channel interfaces for the euler vector rotator
interface evr_in_if #(
  parameter int CoordWidth = evr_pkg::COORD_WIDTH
);
  logic                                  valid;
  logic                                  ready;
  logic signed [evr_pkg::ANGLE_WIDTH-1:0] angle_x;
  logic signed [evr_pkg::ANGLE_WIDTH-1:0] angle_y;
  logic signed [evr_pkg::ANGLE_WIDTH-1:0] angle_z;
  logic signed [CoordWidth-1:0]          vec_x;
  logic signed [CoordWidth-1:0]          vec_y;
  logic signed [CoordWidth-1:0]          vec_z;

  modport source (
    output valid, angle_x, angle_y, angle_z, vec_x, vec_y, vec_z,
    input  ready
  );
  modport sink (
    input  valid, angle_x, angle_y, angle_z, vec_x, vec_y, vec_z,
    output ready
  );
endinterface

interface evr_out_if #(
  parameter int CoordWidth = evr_pkg::COORD_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [CoordWidth-1:0] out_x;
  logic signed [CoordWidth-1:0] out_y;
  logic signed [CoordWidth-1:0] out_z;

  modport source (
    output valid, out_x, out_y, out_z,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z,
    output ready
  );
endinterface

// ----- design/evr_trig.sv -----
// pipelined sine and cosine of an angle in 1/256 degree
module evr_trig #(
  parameter int TrigFracBits = evr_pkg::TRIG_FRAC_BITS
) (
  input  logic                                   clk_i,
  input  logic                                   en_i,
  input  logic signed [evr_pkg::ANGLE_WIDTH-1:0] angle_i,
  output logic signed [TrigFracBits+1:0]         sin_o,
  output logic signed [TrigFracBits+1:0]         cos_o
);

  localparam int AngW     = evr_pkg::ANGLE_WIDTH;
  localparam int BiasW    = AngW + 2;
  localparam int Steps    = evr_pkg::MOD_STEPS;
  localparam int RadW     = evr_pkg::RAD_WIDTH;
  localparam int SerW     = evr_pkg::SERIES_WIDTH;
  localparam int AccW     = evr_pkg::ACC_WIDTH;
  localparam int Frac     = evr_pkg::SERIES_FRAC;
  localparam int NumTerms = evr_pkg::NUM_TERMS;
  localparam int SinTerms = evr_pkg::SIN_TERMS;
  localparam int DivShift = evr_pkg::DIV_SHIFT;
  localparam int DivW     = evr_pkg::DIV_WIDTH;
  localparam int ProdW    = SerW + RadW;
  localparam int QuoW     = SerW + DivW;
  localparam int TrigW    = TrigFracBits + 2;
  localparam int QuadDepth = 3 + 2 * NumTerms;
  localparam logic [SerW-1:0] SeriesOne = SerW'(1) << Frac;
  localparam logic [AccW-1:0] RoundHalf = AccW'(1) << (Frac - 1 - TrigFracBits);

  typedef enum logic [1:0] {
    QUAD_FIRST,
    QUAD_SECOND,
    QUAD_THIRD,
    QUAD_FOURTH
  } quad_e;

  // stage 1: bias to positive, split off turn count by reciprocal
  logic signed [BiasW-1:0] biased;
  logic [13:0]             turn_hi;
  logic [28:0]             hi_prod;
  logic [13:0]             hi_q;
  logic [7:0]              qt_q;
  logic [10:0]             lo_q;

  assign biased  = BiasW'(angle_i) + BiasW'(evr_pkg::ANGLE_BIAS);
  assign turn_hi = biased[24:11];
  assign hi_prod = 29'(turn_hi) * 29'(evr_pkg::MOD_RECIP);

  // stage 2: remainder modulo one turn
  logic [13:0] rem_w;
  logic [7:0]  rhi_q;
  logic [8:0]  rlo_q;

  assign rem_w = hi_q - 14'(qt_q) * 14'(Steps);

  // stage 3: quadrant, fold into first octant
  quad_e       quad_d;
  logic [5:0]  fhi;
  logic [14:0] fold;
  logic        swap_d;
  logic [13:0] g_d;
  logic [13:0] g_q;
  quad_e       quad_q [QuadDepth];
  logic [QuadDepth-1:0] swap_q;

  always_comb begin
    priority if (rhi_q >= 8'(3 * Steps)) begin
      quad_d = QUAD_FOURTH;
    end else if (rhi_q >= 8'(2 * Steps)) begin
      quad_d = QUAD_THIRD;
    end else if (rhi_q >= 8'(Steps)) begin
      quad_d = QUAD_SECOND;
    end else begin
      quad_d = QUAD_FIRST;
    end
    unique case (quad_d)
      QUAD_FIRST:  fhi = rhi_q[5:0];
      QUAD_SECOND: fhi = 6'(rhi_q - 8'(Steps));
      QUAD_THIRD:  fhi = 6'(rhi_q - 8'(2 * Steps));
      QUAD_FOURTH: fhi = 6'(rhi_q - 8'(3 * Steps));
      default:     fhi = rhi_q[5:0];
    endcase
    fold   = {fhi, rlo_q};
    swap_d = fold > 15'(evr_pkg::EIGHTH_UNITS);
    g_d    = swap_d ? 14'(15'(evr_pkg::QUARTER_UNITS) - fold) : fold[13:0];
  end

  // stage 4: radians, stage 5: square
  logic [63:0]     rad_prod;
  logic [RadW-1:0] rad_q;
  logic [59:0]     rad_sq;
  logic [RadW-1:0] rad_d_q;
  logic [RadW-1:0] x2_q;

  assign rad_prod = 64'(g_q) * evr_pkg::RAD_SCALE + (64'd1 << 31);
  assign rad_sq   = 60'(rad_q) * 60'(rad_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_q    <= turn_hi;
      qt_q    <= hi_prod[27:20];
      lo_q    <= biased[10:0];
      rhi_q   <= {rem_w[5:0], lo_q[10:9]};
      rlo_q   <= lo_q[8:0];
      g_q     <= g_d;
      quad_q[0] <= quad_d;
      swap_q[0] <= swap_d;
      for (int i = 1; i < QuadDepth; i++) begin
        quad_q[i] <= quad_q[i-1];
        swap_q[i] <= swap_q[i-1];
      end
      rad_q   <= rad_prod[61:32];
      rad_d_q <= rad_q;
      x2_q    <= rad_sq[59:30];
    end
  end

  // taylor terms, two stages each: multiply by x^2, then divide by constant
  logic [SerW-1:0] s_t   [NumTerms+1];
  logic [AccW-1:0] s_acc [NumTerms+1];
  logic [SerW-1:0] c_t   [NumTerms+1];
  logic [AccW-1:0] c_acc [NumTerms+1];
  logic [RadW-1:0] x2_c  [NumTerms+1];

  assign s_t[0]   = SerW'(rad_d_q);
  assign s_acc[0] = AccW'(rad_d_q);
  assign c_t[0]   = SeriesOne;
  assign c_acc[0] = AccW'(SeriesOne);
  assign x2_c[0]  = x2_q;

  for (genvar n = 0; n < NumTerms; n++) begin : g_term
    localparam longint unsigned CosK = 64'(evr_pkg::cos_div(n + 1));
    localparam logic [DivW-1:0] CosM = DivW'(((64'd1 << DivShift) + CosK - 64'd1) / CosK);

    logic [RadW-1:0]  x2_a_q, x2_b_q;
    logic [ProdW-1:0] c_prod_q;
    logic [QuoW-1:0]  c_quo_q;
    logic [AccW-1:0]  c_acc_a_q, c_acc_b_q;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x2_a_q    <= x2_c[n];
        x2_b_q    <= x2_a_q;
        c_prod_q  <= ProdW'(c_t[n]) * ProdW'(x2_c[n]);
        c_quo_q   <= QuoW'(c_prod_q[ProdW-1:Frac]) * QuoW'(CosM);
        c_acc_a_q <= c_acc[n];
        c_acc_b_q <= c_acc_a_q;
      end
    end

    assign x2_c[n+1] = x2_b_q;
    assign c_t[n+1]  = c_quo_q[QuoW-1:DivShift];

    if ((n % 2) == 0) begin : g_cos_sub
      assign c_acc[n+1] = c_acc_b_q - AccW'(c_t[n+1]);
    end else begin : g_cos_add
      assign c_acc[n+1] = c_acc_b_q + AccW'(c_t[n+1]);
    end

    if (n < SinTerms) begin : g_sin
      localparam longint unsigned SinK = 64'(evr_pkg::sin_div(n + 1));
      localparam logic [DivW-1:0] SinM = DivW'(((64'd1 << DivShift) + SinK - 64'd1) / SinK);

      logic [ProdW-1:0] s_prod_q;
      logic [QuoW-1:0]  s_quo_q;
      logic [AccW-1:0]  s_acc_a_q, s_acc_b_q;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          s_prod_q  <= ProdW'(s_t[n]) * ProdW'(x2_c[n]);
          s_quo_q   <= QuoW'(s_prod_q[ProdW-1:Frac]) * QuoW'(SinM);
          s_acc_a_q <= s_acc[n];
          s_acc_b_q <= s_acc_a_q;
        end
      end

      assign s_t[n+1] = s_quo_q[QuoW-1:DivShift];
      if ((n % 2) == 0) begin : g_sin_sub
        assign s_acc[n+1] = s_acc_b_q - AccW'(s_t[n+1]);
      end else begin : g_sin_add
        assign s_acc[n+1] = s_acc_b_q + AccW'(s_t[n+1]);
      end
    end else begin : g_sin_pass
      logic [AccW-1:0] s_acc_a_q, s_acc_b_q;

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          s_acc_a_q <= s_acc[n];
          s_acc_b_q <= s_acc_a_q;
        end
      end

      assign s_t[n+1]   = '0;
      assign s_acc[n+1] = s_acc_b_q;
    end
  end

  // output stage: round to Q1.F, undo fold and quadrant
  logic [AccW-1:0]         s_rnd, c_rnd;
  logic [TrigFracBits:0]   s_mag, c_mag, so, co;
  logic signed [TrigW-1:0] sin_d, cos_d;

  assign s_rnd = s_acc[NumTerms] + RoundHalf;
  assign c_rnd = c_acc[NumTerms] + RoundHalf;
  assign s_mag = s_rnd[Frac:Frac-TrigFracBits];
  assign c_mag = c_rnd[Frac:Frac-TrigFracBits];

  always_comb begin
    so = swap_q[QuadDepth-1] ? c_mag : s_mag;
    co = swap_q[QuadDepth-1] ? s_mag : c_mag;
    unique case (quad_q[QuadDepth-1])
      QUAD_FIRST: begin
        sin_d = TrigW'(so);
        cos_d = TrigW'(co);
      end
      QUAD_SECOND: begin
        sin_d = TrigW'(co);
        cos_d = -TrigW'(so);
      end
      QUAD_THIRD: begin
        sin_d = -TrigW'(so);
        cos_d = -TrigW'(co);
      end
      QUAD_FOURTH: begin
        sin_d = -TrigW'(co);
        cos_d = TrigW'(so);
      end
      default: begin
        sin_d = TrigW'(so);
        cos_d = TrigW'(co);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= sin_d;
      cos_o <= cos_d;
    end
  end

endmodule

// ----- design/evr_rot.sv -----
// one planar rotation step: (a*c + b*s, b*c - a*s), rounded and saturated
module evr_rot #(
  parameter int CoordWidth   = evr_pkg::COORD_WIDTH,
  parameter int TrigFracBits = evr_pkg::TRIG_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic signed [CoordWidth-1:0]   a_i,
  input  logic signed [CoordWidth-1:0]   b_i,
  input  logic signed [TrigFracBits+1:0] sin_i,
  input  logic signed [TrigFracBits+1:0] cos_i,
  output logic signed [CoordWidth-1:0]   first_o,
  output logic signed [CoordWidth-1:0]   second_o
);

  localparam int ProdW = CoordWidth + TrigFracBits + 2;
  localparam int SumW  = ProdW + 2;
  localparam logic signed [SumW-1:0] Half = SumW'(1) << (TrigFracBits - 1);
  localparam logic signed [SumW-1:0] SatMax =
    {{(SumW - CoordWidth + 1){1'b0}}, {(CoordWidth - 1){1'b1}}};
  localparam logic signed [SumW-1:0] SatMin = ~SatMax;

  logic signed [ProdW-1:0] ac_q, bs_q, bc_q, as_q;
  logic signed [SumW-1:0]  sum1, sum2, sh1, sh2;

  function automatic logic signed [CoordWidth-1:0] sat(input logic signed [SumW-1:0] v);
    logic signed [CoordWidth-1:0] r;
    if (v > SatMax) begin
      r = SatMax[CoordWidth-1:0];
    end else if (v < SatMin) begin
      r = SatMin[CoordWidth-1:0];
    end else begin
      r = v[CoordWidth-1:0];
    end
    return r;
  endfunction

  assign sum1 = SumW'(ac_q) + SumW'(bs_q) + Half;
  assign sum2 = SumW'(bc_q) - SumW'(as_q) + Half;
  assign sh1  = sum1 >>> TrigFracBits;
  assign sh2  = sum2 >>> TrigFracBits;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ac_q     <= a_i * cos_i;
      bs_q     <= b_i * sin_i;
      bc_q     <= b_i * cos_i;
      as_q     <= a_i * sin_i;
      first_o  <= sat(sh1);
      second_o <= sat(sh2);
    end
  end

endmodule

// ----- design/euler_vector_rotator.sv -----
// top level: rotate a 3d point about x, then y, then z by euler angles
//
//  channel   dir  handshake      payload
//  in_i      in   valid/ready    angle_x/y/z (24b, 1/256 deg), vec_x/y/z (Q16.16)
//  out_o     out  valid/ready    out_x/y/z (Q16.16, saturated)
//
// one beat per cycle sustained while the output is not stalled; the sine/cosine
// pipeline comes first, then one rotation step per axis, x, y and z in turn
// the three angles get their sine and cosine in parallel units
// reset clears the valid bits and the in-flight counter; the datapath has no reset
// a stalled output beat freezes the whole pipeline, nothing is lost or repeated
module euler_vector_rotator #(
  parameter int CoordWidth   = evr_pkg::COORD_WIDTH,
  parameter int TrigFracBits = evr_pkg::TRIG_FRAC_BITS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  evr_in_if.sink   in_i,
  evr_out_if.source out_o
);

  localparam int TrigW   = TrigFracBits + 2;
  localparam int TrigLat = evr_pkg::TRIG_LATENCY;
  localparam int RotLat  = evr_pkg::ROT_LATENCY;
  localparam int Lat     = TrigLat + 3 * RotLat;
  localparam int CntW    = $clog2(Lat + 1);

  // pipeline advance: last stage empty or being taken
  logic           en;
  logic [Lat-1:0] vld_q;

  assign en         = !vld_q[Lat-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_i.valid};
    end
  end

  // sine/cosine for each axis
  logic signed [TrigW-1:0] sx, cx, sy, cy, sz, cz;

  evr_trig #(.TrigFracBits(TrigFracBits)) u_trig_x (
    .clk_i, .en_i(en), .angle_i(in_i.angle_x), .sin_o(sx), .cos_o(cx)
  );
  evr_trig #(.TrigFracBits(TrigFracBits)) u_trig_y (
    .clk_i, .en_i(en), .angle_i(in_i.angle_y), .sin_o(sy), .cos_o(cy)
  );
  evr_trig #(.TrigFracBits(TrigFracBits)) u_trig_z (
    .clk_i, .en_i(en), .angle_i(in_i.angle_z), .sin_o(sz), .cos_o(cz)
  );

  // point waits alongside the trig pipeline
  logic signed [CoordWidth-1:0] vx_q [TrigLat];
  logic signed [CoordWidth-1:0] vy_q [TrigLat];
  logic signed [CoordWidth-1:0] vz_q [TrigLat];

  // y and z trig values wait for the earlier axes
  logic signed [TrigW-1:0] sy_q [RotLat];
  logic signed [TrigW-1:0] cy_q [RotLat];
  logic signed [TrigW-1:0] sz_q [2 * RotLat];
  logic signed [TrigW-1:0] cz_q [2 * RotLat];

  // coordinate that each axis step leaves untouched
  logic signed [CoordWidth-1:0] xd_q [RotLat];
  logic signed [CoordWidth-1:0] yd_q [RotLat];
  logic signed [CoordWidth-1:0] zd_q [RotLat];

  logic signed [CoordWidth-1:0] ny1, nz1, nz2, nx2, nx3, ny3;

  always_ff @(posedge clk_i) begin
    if (en) begin
      vx_q[0] <= in_i.vec_x;
      vy_q[0] <= in_i.vec_y;
      vz_q[0] <= in_i.vec_z;
      for (int i = 1; i < TrigLat; i++) begin
        vx_q[i] <= vx_q[i-1];
        vy_q[i] <= vy_q[i-1];
        vz_q[i] <= vz_q[i-1];
      end
      sy_q[0] <= sy;
      cy_q[0] <= cy;
      for (int i = 1; i < RotLat; i++) begin
        sy_q[i] <= sy_q[i-1];
        cy_q[i] <= cy_q[i-1];
      end
      sz_q[0] <= sz;
      cz_q[0] <= cz;
      for (int i = 1; i < 2 * RotLat; i++) begin
        sz_q[i] <= sz_q[i-1];
        cz_q[i] <= cz_q[i-1];
      end
      xd_q[0] <= vx_q[TrigLat-1];
      yd_q[0] <= ny1;
      zd_q[0] <= nz2;
      for (int i = 1; i < RotLat; i++) begin
        xd_q[i] <= xd_q[i-1];
        yd_q[i] <= yd_q[i-1];
        zd_q[i] <= zd_q[i-1];
      end
    end
  end

  // about x: (y, z) -> (c*y + s*z, c*z - s*y)
  evr_rot #(.CoordWidth(CoordWidth), .TrigFracBits(TrigFracBits)) u_rot_x (
    .clk_i, .en_i(en),
    .a_i(vy_q[TrigLat-1]), .b_i(vz_q[TrigLat-1]),
    .sin_i(sx), .cos_i(cx),
    .first_o(ny1), .second_o(nz1)
  );

  // about y: (z, x) -> (c*z + s*x, c*x - s*z)
  evr_rot #(.CoordWidth(CoordWidth), .TrigFracBits(TrigFracBits)) u_rot_y (
    .clk_i, .en_i(en),
    .a_i(nz1), .b_i(xd_q[RotLat-1]),
    .sin_i(sy_q[RotLat-1]), .cos_i(cy_q[RotLat-1]),
    .first_o(nz2), .second_o(nx2)
  );

  // about z: (x, y) -> (c*x + s*y, c*y - s*x); these registers are the output beat
  evr_rot #(.CoordWidth(CoordWidth), .TrigFracBits(TrigFracBits)) u_rot_z (
    .clk_i, .en_i(en),
    .a_i(nx2), .b_i(yd_q[RotLat-1]),
    .sin_i(sz_q[2*RotLat-1]), .cos_i(cz_q[2*RotLat-1]),
    .first_o(nx3), .second_o(ny3)
  );

  assign out_o.valid = vld_q[Lat-1];
  assign out_o.out_x = nx3;
  assign out_o.out_y = ny3;
  assign out_o.out_z = zd_q[RotLat-1];

  // beats in flight, for checking the valid pipeline
  logic [CntW-1:0] inflight_q;
  logic            in_beat, out_beat;

  assign in_beat  = in_i.valid && in_i.ready;
  assign out_beat = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + CntW'(in_beat) - CntW'(out_beat);
    end
  end

  a_inflight_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(inflight_q) == $countones(vld_q))
    else $error("in-flight count disagrees with valid bits");

  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("valid bits moved during a stall");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> vld_q[0])
    else $error("accepted beat did not enter the pipeline");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("input stalled with empty output stage");

endmodule

// ----- verif/euler_vector_rotator_tb.sv -----
// self-checking testbench for the euler vector rotator: directed table, then random beats
module euler_vector_rotator_tb;

  localparam int NUM_RANDOM  = 1300;
  localparam int TAIL_QUIET  = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT     = 400;
  localparam int WDOG_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 40;
  localparam int AngW        = evr_pkg::ANGLE_WIDTH;
  localparam int CoordW      = evr_pkg::COORD_WIDTH;
  localparam int FracW       = evr_pkg::TRIG_FRAC_BITS;
  localparam int Turn        = evr_pkg::TURN_UNITS;
  localparam int Quarter     = evr_pkg::QUARTER_UNITS;
  localparam int Eighth      = evr_pkg::EIGHTH_UNITS;

  typedef struct packed {
    logic signed [AngW-1:0]   ax, ay, az;
    logic signed [CoordW-1:0] vx, vy, vz;
  } point_beat_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x, y, z;
  } coord_t;

  typedef struct {
    point_beat_t beat;
    logic        typed;
    coord_t      want;
  } table_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  evr_in_if  in_bus ();
  evr_out_if out_bus ();

  euler_vector_rotator u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  coord_t     rotated_q[$];
  coord_t     typed_q[$];
  logic       typed_flag_q[$];
  table_row_t rows[$];
  int         fail_cnt = 0;
  int         sent_cnt = 0;
  int         idle_cycles = 0;
  logic       quiet = 1'b0;
  logic       hold_done = 1'b0;

  // round half up at the trig fraction, saturate to coordinate width
  function automatic logic signed [CoordW-1:0] dot_round(longint a, longint p,
                                                         longint b, longint q);
    logic signed [127:0] wa, wp, wb, wq, acc;
    wa = a; wp = p; wb = b; wq = q;
    acc = wa * wp + wb * wq + (128'sd1 <<< (FracW - 1));
    acc = acc >>> FracW;
    if (acc > 128'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (acc < -128'sh80000000) return 32'sh80000000;
    return acc[CoordW-1:0];
  endfunction

  // taylor sine and cosine over the first octant, q1.16
  function automatic void octant_trig(input longint g, output longint sn, output longint cs);
    logic [63:0] k, x, x2, t, s, c;
    k  = evr_pkg::PI_Q62 / 64'd46080;
    x  = (64'(g) * k + 64'h8000_0000) >> 32;
    x2 = (x * x) >> 30;
    t = x; s = x;
    for (int n = 1; n <= 5; n++) begin
      t = ((t * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) s = s - t; else s = s + t;
    end
    t = 64'd1 << 30; c = t;
    for (int n = 1; n <= 6; n++) begin
      t = ((t * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) c = c - t; else c = c + t;
    end
    sn = longint'((s + (64'd1 << (29 - FracW))) >> (30 - FracW));
    cs = longint'((c + (64'd1 << (29 - FracW))) >> (30 - FracW));
  endfunction

  // full-turn reduction, octant fold and quadrant signs
  function automatic void angle_trig(input logic signed [AngW-1:0] ang,
                                     output longint sn, output longint cs);
    int     r, q, f;
    logic   swap;
    longint so, co, tmp;
    r = int'(ang) % Turn;
    if (r < 0) r += Turn;
    q = r / Quarter;
    f = r % Quarter;
    swap = f > Eighth;
    octant_trig(swap ? Quarter - f : f, so, co);
    if (swap) begin
      tmp = so; so = co; co = tmp;
    end
    case (q)
      0: begin sn = so;  cs = co;  end
      1: begin sn = co;  cs = -so; end
      2: begin sn = -so; cs = -co; end
      default: begin sn = -co; cs = so; end
    endcase
  endfunction

  function automatic coord_t rotate_point(point_beat_t b);
    longint x, y, z, s, c, nx, ny, nz;
    coord_t r;
    x = b.vx; y = b.vy; z = b.vz;
    angle_trig(b.ax, s, c);
    ny = dot_round(y, c, z, s);
    nz = dot_round(z, c, y, -s);
    y = ny; z = nz;
    angle_trig(b.ay, s, c);
    nx = dot_round(x, c, z, -s);
    nz = dot_round(x, s, z, c);
    x = nx; z = nz;
    angle_trig(b.az, s, c);
    nx = dot_round(x, c, y, s);
    ny = dot_round(y, c, x, -s);
    r.x = nx; r.y = ny; r.z = nz;
    return r;
  endfunction

  task automatic add_row(int ax, int ay, int az, int vx, int vy, int vz, logic typed,
                         int ex, int ey, int ez);
    table_row_t r;
    r.beat  = '{ax: AngW'(ax), ay: AngW'(ay), az: AngW'(az),
                vx: CoordW'(vx), vy: CoordW'(vy), vz: CoordW'(vz)};
    r.typed = typed;
    r.want  = '{x: CoordW'(ex), y: CoordW'(ey), z: CoordW'(ez)};
    rows.push_back(r);
  endtask

  function automatic int rand_angle();
    case ($urandom_range(0, 2))
      0: return int'($urandom_range(0, 32'hFFFFFF)) - 8388608;
      1: return int'($urandom_range(0, 2 * Turn)) - Turn;
      default: return Quarter * (int'($urandom_range(0, 8)) - 4)
                      + int'($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  function automatic int rand_coord();
    if ($urandom_range(0, 1)) return int'($urandom());
    return int'($urandom_range(0, 1 << 22)) - (1 << 21);
  endfunction

  // scoreboard: predict on every input beat, check every output beat
  always @(posedge clk_i) begin
    coord_t want;
    logic   typed;
    if (in_bus.valid && in_bus.ready) begin
      rotated_q.push_back(rotate_point('{ax: in_bus.angle_x, ay: in_bus.angle_y,
                                         az: in_bus.angle_z, vx: in_bus.vec_x,
                                         vy: in_bus.vec_y, vz: in_bus.vec_z}));
    end
    if (out_bus.valid && out_bus.ready) begin
      if (rotated_q.size() == 0) begin
        $display("%0t: unexpected output beat %h %h %h", $time,
                 out_bus.out_x, out_bus.out_y, out_bus.out_z);
        fail_cnt++;
      end else begin
        want = rotated_q.pop_front();
        if (want.x !== out_bus.out_x) begin
          $display("%0t: out_x expected %h actual %h", $time, want.x, out_bus.out_x);
          fail_cnt++;
        end
        if (want.y !== out_bus.out_y) begin
          $display("%0t: out_y expected %h actual %h", $time, want.y, out_bus.out_y);
          fail_cnt++;
        end
        if (want.z !== out_bus.out_z) begin
          $display("%0t: out_z expected %h actual %h", $time, want.z, out_bus.out_z);
          fail_cnt++;
        end
        // table rows with a hand-written answer are checked against it too
        if (typed_flag_q.size() > 0) begin
          typed = typed_flag_q.pop_front();
          if (typed) begin
            want = typed_q.pop_front();
            if (want !== {out_bus.out_x, out_bus.out_y, out_bus.out_z}) begin
              $display("%0t: table row expected %h actual %h %h %h", $time, want,
                       out_bus.out_x, out_bus.out_y, out_bus.out_z);
              fail_cnt++;
            end
          end
        end
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, one long hold-off, none at the tail
  initial begin
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (quiet) begin
        out_bus.ready <= 1'b1;
        @(posedge clk_i);
      end else if (!hold_done && sent_cnt >= HOLD_AT) begin
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_bus.ready <= ($urandom_range(0, 2) != 0);
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  task automatic send_beat(point_beat_t b);
    // random gap before about one beat in four, skipped at the tail
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.angle_x <= b.ax;
    in_bus.angle_y <= b.ay;
    in_bus.angle_z <= b.az;
    in_bus.vec_x   <= b.vx;
    in_bus.vec_y   <= b.vy;
    in_bus.vec_z   <= b.vz;
    do @(posedge clk_i); while (!in_bus.ready);
    sent_cnt++;
  endtask

  initial begin
    point_beat_t b;
    in_bus.valid   = 1'b0;
    in_bus.angle_x = '0;
    in_bus.angle_y = '0;
    in_bus.angle_z = '0;
    in_bus.vec_x   = '0;
    in_bus.vec_y   = '0;
    in_bus.vec_z   = '0;

    // zero angles and whole turns pass the point through untouched
    add_row(0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
    add_row(0, 0, 0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, 1,
            32'h7FFFFFFF, 32'h80000000, 32'h00010000);
    add_row(0, 0, 0, 32'h80000000, 32'h7FFFFFFF, -1, 1, 32'h80000000, 32'h7FFFFFFF, -1);
    add_row(Turn, -Turn, 2 * Turn, 32'h12345678, -5, 7, 1,
            32'h12345678, -5, 7);
    // quarter turns, octant edges, half and three-quarter turns
    add_row(Quarter, Quarter, Quarter, 32'h10000, 32'h20000, 32'h30000,
            0, 0, 0, 0);
    add_row(Eighth, Eighth, Eighth, 32'h10000, -32'h10000, 32'h8000,
            0, 0, 0, 0);
    add_row(Eighth + 1, Eighth - 1, Quarter - 1, 32'h10000, 32'h10000,
            32'h10000, 0, 0, 0, 0);
    add_row(2 * Quarter, 3 * Quarter, 1, 32'h10000, 32'h20000, -32'h30000,
            0, 0, 0, 0);
    add_row(-Quarter, -1, -Eighth, 32'h10000, 32'h20000, 32'h30000, 0, 0, 0, 0);
    // angle field extremes, wrapped into one turn
    add_row(32'h7FFFFF, 32'h7FFFFF, 32'h7FFFFF, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 0);
    add_row(-8388608, -8388608, -8388608, 32'h10000, 32'h10000, 32'h10000, 0, 0, 0, 0);
    add_row(8388607, -8388608, 0, -32'h7654321, 32'h1234567, 32'h0ABCDEF, 0, 0, 0, 0);
    // saturation inside and between stages
    add_row(Eighth, Eighth, Eighth, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'h7FFFFFFF, 0, 0, 0, 0);
    add_row(Eighth, -Eighth, 3 * Eighth, 32'h80000000, 32'h80000000,
            32'h80000000, 0, 0, 0, 0);
    add_row(-Eighth, Eighth, 5 * Eighth, 32'h7FFFFFFF, 32'h80000000,
            32'h7FFFFFFF, 0, 0, 0, 0);
    add_row(1, 1, 1, 1, -1, 1, 0, 0, 0, 0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      typed_flag_q.push_back(rows[i].typed);
      if (rows[i].typed) typed_q.push_back(rows[i].want);
      send_beat(rows[i].beat);
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM - TAIL_QUIET) quiet = 1'b1;
      b.ax = AngW'(rand_angle());
      b.ay = AngW'(rand_angle());
      b.az = AngW'(rand_angle());
      b.vx = CoordW'(rand_coord());
      b.vy = CoordW'(rand_coord());
      b.vz = CoordW'(rand_coord());
      send_beat(b);
    end
    quiet = 1'b1;
    in_bus.valid <= 1'b0;

    while (rotated_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (rotated_q.size() != 0) begin
      $display("%0t: %0d output beats never arrived", $time, rotated_q.size());
      fail_cnt++;
    end

    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
